@@ rtl/dual_triangle_tone_synth_macros.svh @@
// assertion macros for the dual triangle tone synth
// used by the top level only, no other dependencies
`ifndef DUAL_TRIANGLE_TONE_SYNTH_MACROS_SVH
`define DUAL_TRIANGLE_TONE_SYNTH_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, clocked on i_clk, off while in reset
`define DTTS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dtts assertion failed");

// next-cycle implication, clocked on i_clk, off while in reset
`define DTTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dtts assertion failed");

`else

`define DTTS_ASSERT_SAME(lbl, ante, cons)
`define DTTS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/dtts_pkg.sv @@
// shared types and constants for the dual triangle tone synth
// no dependencies; imported by dtts_div and dual_triangle_tone_synth
package dtts_pkg;

    localparam int DIV_NUM_W = 30;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [9:0]  FREQ_A_BASE = 10'd180;
    localparam logic [7:0]  FREQ_A_SPAN = 8'd240;
    localparam logic [9:0]  FREQ_B_BASE = 10'd270;

    localparam logic [15:0] RATE_RESET  = 16'd48000;
    localparam logic [15:0] TRI_OFFSET  = 16'd16384;
    localparam logic [14:0] ENV_PEAK    = 15'd16384;
    localparam logic [14:0] ENV_FULL    = 15'd32767;
    // ceil(2^18 / 5), reciprocal for the divide by five
    localparam logic [15:0] MIX_RECIP   = 16'd52429;

    // quotient bit counts for each division
    localparam logic [DIV_CNT_W-1:0] LEN_STEP = 5'd26;
    localparam logic [DIV_CNT_W-1:0] LEN_ENV  = 5'd30;

    // divider request, dividend left-aligned in num
    typedef struct packed {
        logic                 go;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] len;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ rtl/dtts_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on dtts_pkg for the request and response structs
module dtts_div
    import dtts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    assign trial = {r_rem, r_q[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_rem  <= '0;
                r_q    <= i_req.num;
                r_den  <= i_req.den;
                r_cnt  <= i_req.len;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                r_q   <= {r_q[DIV_NUM_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

@@ rtl/dual_triangle_tone_synth.sv @@
// channel    | handshake                 | payload
// -----------+---------------------------+--------------------------------
// tick in    | i_in_valid / o_in_stall   | i_tone_a_color, i_tone_b_color
// sample out | o_out_valid / i_out_stall | o_audio_sample
// config     | i_cfg_we                  | i_cfg_data (sample_rate)
//
// three divisions of 26, 26 and 30 quotient bits share one restoring divider in turn (no
// envelope division without a period, i.e. when sample_rate is below 2), then five steps
// of mix, scale and output load
// input stalls from acceptance until the sample is loaded, longer while a sample waits
// reset is synchronous and active low: sample_rate 48000, phases and envelope position cleared
//
// top level of the dual triangle tone synth
// depends on dtts_pkg, dtts_div and dual_triangle_tone_synth_macros.svh
`include "dual_triangle_tone_synth_macros.svh"

module dual_triangle_tone_synth
    import dtts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    // tick input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_tone_a_color,
    input  logic [7:0]  i_tone_b_color,
    // sample output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [15:0] o_audio_sample
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_A,
        S_DIV_B,
        S_DIV_ENV,
        S_MIX,
        S_DIV_MIX,
        S_MUL,
        S_SCALE,
        S_EMIT
    } t_state;

    t_state   r_state;
    t_div_req r_div_req;
    t_div_rsp div_rsp;

    // architectural state
    logic [15:0] r_rate;
    logic [15:0] r_phase_a;
    logic [15:0] r_phase_b;
    logic [15:0] r_pos;

    // per-request working registers
    logic [9:0]         r_fb;
    logic [14:0]        r_env;
    logic               r_neg;
    logic [16:0]        r_mix_abs;
    logic signed [15:0] r_mix;
    logic signed [29:0] r_prod;
    logic [14:0]        r_out_q;
    logic               r_out_valid;
    logic signed [15:0] r_sample;

    dtts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    // tone frequencies, colour a reduced mod 240 (colour b is always below 360)
    logic [7:0] a_mod;
    logic [9:0] freq_a;
    logic [9:0] freq_b;

    assign a_mod  = (i_tone_a_color >= FREQ_A_SPAN) ? (i_tone_a_color - FREQ_A_SPAN)
                                                    : i_tone_a_color;
    assign freq_a = FREQ_A_BASE + {2'b00, a_mod};
    assign freq_b = FREQ_B_BASE + {2'b00, i_tone_b_color};

    // phase step is the low half of the quotient, zero when the rate is zero
    logic [15:0] step;
    assign step = (r_rate == '0) ? '0 : div_rsp.quot[15:0];

    // envelope position, wrapped to zero if it sits at or past a lowered period
    logic [14:0] half;
    logic [14:0] pos_eff;
    logic [15:0] pos_inc;
    logic [29:0] env_num;

    assign half    = r_rate[15:1];
    assign pos_eff = (r_pos < {1'b0, half}) ? r_pos[14:0] : '0;
    assign pos_inc = {1'b0, pos_eff} + 16'd1;
    // pos * 32767 as a shift and subtract
    assign env_num = {pos_eff, 15'd0} - {15'd0, pos_eff};

    // envelope fold on the quotient
    logic [14:0] env_q;
    assign env_q = div_rsp.quot[14:0];

    // divider launches: phase steps for every request, envelope only with a period
    logic div_launch;
    logic emit;

    assign div_launch = ((r_state == S_IDLE) && i_in_valid) ||
                        ((r_state == S_DIV_A) && div_rsp.done) ||
                        ((r_state == S_DIV_B) && div_rsp.done && (half != '0));
    // the output register is free or is being emptied this cycle
    assign emit       = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    // triangle folds of the updated phases
    logic signed [15:0] wave_a;
    logic signed [15:0] wave_b;
    logic signed [17:0] mix_sum;
    logic [16:0]        mix_abs;

    assign wave_a  = $signed({1'b0, (r_phase_a[15] ? ~r_phase_a[14:0] : r_phase_a[14:0])})
                   - $signed(TRI_OFFSET);
    assign wave_b  = $signed({1'b0, (r_phase_b[15] ? ~r_phase_b[14:0] : r_phase_b[14:0])})
                   - $signed(TRI_OFFSET);
    // 3a + 2b
    assign mix_sum = (18'(wave_a) <<< 1) + 18'(wave_a) + (18'(wave_b) <<< 1);
    assign mix_abs = mix_sum[17] ? 17'(-mix_sum) : mix_sum[16:0];

    // divide by five as a reciprocal multiply, exact for magnitudes below 2^18
    logic [32:0] mix_prod;
    logic [14:0] mix_q;

    assign mix_prod = {16'd0, r_mix_abs} * {17'd0, MIX_RECIP};
    assign mix_q    = mix_prod[32:18];

    // scaled product and its magnitude
    logic signed [31:0] prod_full;
    logic [28:0]        prod_abs;

    assign prod_full = r_mix * $signed({1'b0, r_env});
    assign prod_abs  = r_prod[29] ? 29'(-r_prod) : r_prod[28:0];

    // divide by 32767: (x + (x >> 15) + 1) >> 15, exact over the product range
    logic [29:0] out_sum;
    logic [14:0] out_q;

    assign out_sum = {1'b0, prod_abs} + {16'd0, prod_abs[28:15]} + 30'd1;
    assign out_q   = out_sum[29:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_div_req.go  <= 1'b0;
            r_rate        <= RATE_RESET;
            r_phase_a     <= '0;
            r_phase_b     <= '0;
            r_pos         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_div_req.go <= div_launch;

            if (i_cfg_we) begin
                r_rate <= i_cfg_data;
            end

            // output register fills on emit, empties when downstream takes the sample
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_fb          <= freq_b;
                        r_div_req.num <= {freq_a, 20'd0};
                        r_div_req.den <= r_rate;
                        r_div_req.len <= LEN_STEP;
                        r_state       <= S_DIV_A;
                    end
                end
                S_DIV_A: begin
                    if (div_rsp.done) begin
                        r_phase_a     <= r_phase_a + step;
                        r_div_req.num <= {r_fb, 20'd0};
                        r_div_req.den <= r_rate;
                        r_div_req.len <= LEN_STEP;
                        r_state       <= S_DIV_B;
                    end
                end
                S_DIV_B: begin
                    if (div_rsp.done) begin
                        r_phase_b <= r_phase_b + step;
                        if (half == '0) begin
                            // no envelope period: silent sample
                            r_env   <= '0;
                            r_pos   <= '0;
                            r_state <= S_MIX;
                        end else begin
                            r_div_req.num <= env_num;
                            r_div_req.den <= {1'b0, half};
                            r_div_req.len <= LEN_ENV;
                            r_pos         <= (pos_inc >= {1'b0, half}) ? '0 : pos_inc;
                            r_state       <= S_DIV_ENV;
                        end
                    end
                end
                S_DIV_ENV: begin
                    if (div_rsp.done) begin
                        r_env   <= (env_q > ENV_PEAK) ? (ENV_FULL - env_q) : env_q;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_neg     <= mix_sum[17];
                    r_mix_abs <= mix_abs;
                    r_state   <= S_DIV_MIX;
                end
                S_DIV_MIX: begin
                    r_mix   <= r_neg ? -$signed({1'b0, mix_q})
                                     :  $signed({1'b0, mix_q});
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= prod_full[29:0];
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_neg   <= r_prod[29];
                    r_out_q <= out_q;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit) begin
                        r_sample <= r_neg ? -$signed({1'b0, r_out_q})
                                          :  $signed({1'b0, r_out_q});
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_audio_sample = r_sample;

    // a division is only launched into an idle divider
    `DTTS_ASSERT_SAME(a_div_go_idle, r_div_req.go, !div_rsp.busy)
    // a finished division only arrives while the sequencer waits for one
    `DTTS_ASSERT_SAME(a_done_in_wait, div_rsp.done,
        r_state == S_DIV_A || r_state == S_DIV_B || r_state == S_DIV_ENV)
    // an accepted tick starts a division and blocks further input
    `DTTS_ASSERT_NEXT(a_accept_launch, i_in_valid && !o_in_stall,
        r_div_req.go && o_in_stall)

endmodule
